@@ rtl/core/obst_pkg.sv @@
// Shared types and constants for the optimal binary search tree cost table.
package obst_pkg;

	// Fixed field widths of the transaction payloads.
	localparam int WEIGHT_W = 12;
	localparam int START_W  = 3;
	localparam int END_W    = 4;
	localparam int COST_W   = 19;
	localparam int ROOT_W   = 4;

	// One incoming key.
	typedef struct packed {
		logic [WEIGHT_W-1:0] key_weight;
		logic                last_key;
	} obst_in_t;

	// One finished span.
	typedef struct packed {
		logic [START_W-1:0] span_start;
		logic [END_W-1:0]   span_end;
		logic [COST_W-1:0]  span_cost;
		logic [ROOT_W-1:0]  best_root;
		logic               last_result;
		logic               overflow;
	} obst_out_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_DRAIN,
		ST_WRITE
	} obst_state_t;

endpackage

@@ rtl/core/optimal_bst_cost_table.sv @@
// Optimal binary search tree cost table: key loader, cost memory and span sequencer.
//
// Keys are loaded one per transaction (start high while busy is low), in ascending
// order; the transaction whose last_key is set starts the run. Up to MAX_KEYS keys are
// kept, later ones are dropped and the overflow bit is set on every result of that set.
// During the run busy is high and no key is taken. Spans are solved by increasing
// length and then by increasing start, and each span is presented on result for one
// cycle with result_valid high as soon as it is solved; the receiver cannot stall.
// A span of length L reads its L candidate roots in turn, through the two read ports of the
// cost memory into a single compare-and-accumulate unit, then passes one drain and one
// write-back state. The cost memory needs no clearing: every entry is written in a run
// before it is read, and the diagonal reads as zero.
module optimal_bst_cost_table #(
	parameter int MAX_KEYS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  obst_pkg::obst_in_t  item,
	output logic              result_valid,
	output obst_pkg::obst_out_t result
);
	import obst_pkg::*;

	localparam int IW    = $clog2(MAX_KEYS + 1);
	localparam int WIW   = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
	localparam int SUM_W = WEIGHT_W + IW;
	localparam int CMP_W = COST_W + 1;
	localparam int DEPTH = 1 << (2 * IW);

	// Key store, control state and span counters.
	logic [WEIGHT_W-1:0] weight_q [MAX_KEYS];
	logic [IW-1:0]       key_count_q;
	logic                overflow_seen_q;
	logic                run_ovf_q;
	logic [IW-1:0]       n_q;
	logic [IW-1:0]       len_q;
	logic [IW-1:0]       i_q;
	logic [IW-1:0]       k_q;
	logic [SUM_W-1:0]    w_q;
	logic [CMP_W-1:0]    best_q;
	logic [IW-1:0]       root_q;
	obst_state_t         state_q, state_d;

	// Cost memory and its registered read stage.
	logic [COST_W-1:0] cost_mem [DEPTH];
	logic [COST_W-1:0] rd_a_s1, rd_b_s1;
	logic              valid_s1, diag_a_s1, diag_b_s1;
	logic [IW-1:0]     k_s1;

	logic              accept;
	logic              store_full;
	logic [IW-1:0]     n_now;
	logic [IW-1:0]     j_w;
	logic              first_k;
	logic              mem_we;
	logic [CMP_W-1:0]  cand;
	logic [CMP_W-1:0]  total;
	logic [WEIGHT_W-1:0] k_weight;

	assign accept     = start && !busy;
	assign store_full = (key_count_q == IW'(MAX_KEYS));
	assign n_now      = store_full ? key_count_q : key_count_q + IW'(1);
	assign j_w        = i_q + len_q;
	assign first_k    = (k_q == i_q + IW'(1));
	assign k_weight   = weight_q[WIW'(k_q - IW'(1))];
	assign cand       = (diag_a_s1 ? CMP_W'(0) : CMP_W'(rd_a_s1))
	                  + (diag_b_s1 ? CMP_W'(0) : CMP_W'(rd_b_s1));
	assign total      = best_q + CMP_W'(w_q);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and sequencer outputs.
	always_comb begin
		state_d = state_q;
		busy    = 1'b1;
		mem_we  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (accept && item.last_key) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				if (k_q == j_w) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				mem_we  = 1'b1;
				state_d = (len_q == n_q) ? ST_IDLE : ST_READ;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Key loading and per-set control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q     <= '0;
			overflow_seen_q <= 1'b0;
			run_ovf_q       <= 1'b0;
			n_q             <= '0;
		end else if (accept) begin
			if (item.last_key) begin
				key_count_q     <= '0;
				overflow_seen_q <= 1'b0;
				run_ovf_q       <= overflow_seen_q | store_full;
				n_q             <= n_now;
			end else begin
				key_count_q     <= n_now;
				overflow_seen_q <= overflow_seen_q | store_full;
			end
		end
	end

	// Weight store, written as keys arrive.
	always_ff @(posedge clk) begin
		if (accept && !store_full) begin
			weight_q[WIW'(key_count_q)] <= item.key_weight;
		end
	end

	// Span counters and the candidate root counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			i_q   <= '0;
			k_q   <= '0;
		end else begin
			priority if (accept && item.last_key) begin
				len_q <= IW'(1);
				i_q   <= '0;
				k_q   <= IW'(1);
			end else if (state_q == ST_READ && k_q != j_w) begin
				k_q <= k_q + IW'(1);
			end else if (state_q == ST_WRITE) begin
				if (j_w == n_q) begin
					len_q <= len_q + IW'(1);
					i_q   <= '0;
					k_q   <= IW'(1);
				end else begin
					i_q <= i_q + IW'(1);
					k_q <= i_q + IW'(2);
				end
			end else begin
				len_q <= len_q;
				i_q   <= i_q;
				k_q   <= k_q;
			end
		end
	end

	// Weight sum of the span, built one key per read cycle.
	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			w_q <= first_k ? SUM_W'(k_weight) : w_q + SUM_W'(k_weight);
		end
	end

	// Cost memory: one write port, two registered read ports.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			cost_mem[{i_q, j_w}] <= total[COST_W-1:0];
		end
		rd_a_s1 <= cost_mem[{i_q, k_q - IW'(1)}];
		rd_b_s1 <= cost_mem[{k_q, j_w}];
	end

	// Read stage tags; empty spans on the diagonal count as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (state_q == ST_READ);
		end
	end

	always_ff @(posedge clk) begin
		diag_a_s1 <= first_k;
		diag_b_s1 <= (k_q == j_w);
		k_s1      <= k_q;
	end

	// Running minimum over candidate roots; the earliest root wins a tie.
	always_ff @(posedge clk) begin
		if (valid_s1 && (diag_a_s1 || cand < best_q)) begin
			best_q <= cand;
			root_q <= k_s1;
		end
	end

	// Result register, loaded on the write-back cycle of each span.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= mem_we;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			result.span_start  <= START_W'(i_q);
			result.span_end    <= END_W'(j_w);
			result.span_cost   <= total[COST_W-1:0];
			result.best_root   <= ROOT_W'(root_q);
			result.last_result <= (len_q == n_q);
			result.overflow    <= run_ovf_q;
		end
	end

	// Each span passes through its read, drain and write-back states, so results never come back to back.
	a_result_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("results in consecutive cycles");

	// The whole-set result ends the run.
	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.last_result) |-> !busy)
		else $error("still busy after the final span");

	// A key without the last mark leaves the block free for the next key.
	a_load_no_run: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !item.last_key) |=> !busy)
		else $error("run started without the last key");

	// The last key always starts a run.
	a_last_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.last_key) |=> busy)
		else $error("last key did not start a run");

endmodule
